/* rtl/pcu_pkg.sv */
package pcu_pkg;

    // width of the input counts
    localparam int IN_BITS = 31;
    // width of the result value, limit is 2^VALUE_BITS - 1
    localparam int VALUE_BITS = 31;
    // full width of one multiplier product
    localparam int PROD_BITS = VALUE_BITS + IN_BITS;
    // divide step counter
    localparam int DCNT_BITS = $clog2(VALUE_BITS + 1);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ORDER    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic CMD_PERM = 1'b0;
    localparam logic CMD_COMB = 1'b1;

    typedef struct packed {
        logic [IN_BITS-1:0] count_total;
        logic [IN_BITS-1:0] count_chosen;
        logic               command;
    } t_req;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [1:0]            status;
    } t_rsp;

endpackage

/* rtl/permutation_combination_unit_core.sv */
// channel    direction  handshake          payload
// request    in         i_valid / o_stall  i_req (t_req)
// response   out        o_valid / i_stall  o_rsp (t_rsp)
//
// a < b goes straight to S_DONE with an order error; P(a,b) applies the b
//   factors on the shared multiplier, which stops at the first product past
//   the limit, and b never exceeds 12 for a product that fits
// C(a,b) then forms b! on the same multiplier and runs the restoring divider,
//   one quotient bit per cycle, for VALUE_BITS quotient bits
// one request in flight; o_stall is high from accept until the result moves
//   into the output register, the next transfer can follow in the cycle after
// a stalled output keeps the sequencer in S_DONE only while the output
//   register still holds the previous result
// reset (synchronous, active low) clears the sequencer and the output valid
module permutation_combination_unit_core
    import pcu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    // one-hot sequencer
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,  // running product of a-b+1 .. a
        S_FAC  = 5'b00100,  // b! on the same multiplier
        S_DIV  = 5'b01000,  // product / b!, one bit per cycle
        S_DONE = 5'b10000   // result ready for the output register
    } t_state;

    t_state                r_state, n_state;
    logic                  r_cmd, n_cmd;
    logic [IN_BITS-1:0]    r_chosen, n_chosen;  // b, kept for the factorial
    logic [IN_BITS-1:0]    r_x, n_x;          // current factor
    logic [IN_BITS-1:0]    r_rem, n_rem;      // factors still to apply
    logic [VALUE_BITS-1:0] r_prod, n_prod;    // running product, then quotient
    logic [VALUE_BITS-1:0] r_fac, n_fac;      // factorial divisor
    logic [VALUE_BITS-1:0] r_drem, n_drem;    // divider partial remainder
    logic [DCNT_BITS-1:0]  r_dcnt, n_dcnt;
    logic [VALUE_BITS-1:0] r_res_value, n_res_value;
    logic [1:0]            r_res_status, n_res_status;
    logic                  r_out_valid, n_out_valid;
    t_rsp                  r_rsp, n_rsp;

    // shared multiplier
    logic [VALUE_BITS-1:0] w_mul_a;
    logic [PROD_BITS-1:0]  w_prod;
    logic                  w_mul_ovf;

    // divider step
    logic [VALUE_BITS:0]   w_shift;
    logic [VALUE_BITS:0]   w_div;
    logic                  w_ge;

    logic w_in_xfer;
    logic w_out_xfer;
    logic w_load_out;

    assign w_mul_a   = (r_state == S_FAC) ? r_fac : r_prod;
    assign w_prod    = PROD_BITS'(w_mul_a) * PROD_BITS'(r_x);
    // exact check: anything above the value width means past the limit
    assign w_mul_ovf = |w_prod[PROD_BITS-1:VALUE_BITS];

    assign w_shift = {r_drem, r_prod[VALUE_BITS-1]};
    assign w_div   = {1'b0, r_fac};
    assign w_ge    = (w_shift >= w_div);

    assign o_stall    = (r_state != S_IDLE);
    assign w_in_xfer  = i_valid && !o_stall;
    assign w_out_xfer = r_out_valid && !i_stall;
    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_chosen     = r_chosen;
        n_x          = r_x;
        n_rem        = r_rem;
        n_prod       = r_prod;
        n_fac        = r_fac;
        n_drem       = r_drem;
        n_dcnt       = r_dcnt;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_cmd    = i_req.command;
                    n_chosen = i_req.count_chosen;
                    if (i_req.count_total < i_req.count_chosen) begin
                        n_res_value  = '0;
                        n_res_status = ST_ORDER;
                        n_state      = S_DONE;
                    end else begin
                        // first factor a-b+1, b factors in all
                        n_x     = i_req.count_total - i_req.count_chosen + IN_BITS'(1);
                        n_rem   = i_req.count_chosen;
                        n_prod  = VALUE_BITS'(1);
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                if (r_rem == '0) begin
                    if (r_cmd == CMD_COMB) begin
                        // b! as the product of 1 .. b
                        n_fac   = VALUE_BITS'(1);
                        n_x     = IN_BITS'(1);
                        n_rem   = r_chosen;
                        n_state = S_FAC;
                    end else begin
                        n_res_value  = r_prod;
                        n_res_status = ST_OK;
                        n_state      = S_DONE;
                    end
                end else if (w_mul_ovf) begin
                    n_res_value  = '0;
                    n_res_status = ST_OVERFLOW;
                    n_state      = S_DONE;
                end else begin
                    n_prod = w_prod[VALUE_BITS-1:0];
                    n_x    = r_x + IN_BITS'(1);
                    n_rem  = r_rem - IN_BITS'(1);
                end
            end
            S_FAC: begin
                if (r_rem == '0) begin
                    n_drem  = '0;
                    n_dcnt  = DCNT_BITS'(VALUE_BITS);
                    n_state = S_DIV;
                end else if (w_mul_ovf) begin
                    // b! never exceeds P(a,b), kept for completeness
                    n_res_value  = '0;
                    n_res_status = ST_OVERFLOW;
                    n_state      = S_DONE;
                end else begin
                    n_fac = w_prod[VALUE_BITS-1:0];
                    n_x   = r_x + IN_BITS'(1);
                    n_rem = r_rem - IN_BITS'(1);
                end
            end
            S_DIV: begin
                if (r_dcnt == '0) begin
                    n_res_value  = r_prod;
                    n_res_status = ST_OK;
                    n_state      = S_DONE;
                end else begin
                    // restoring step, quotient shifts into the product register
                    n_drem = w_shift[VALUE_BITS-1:0];
                    if (w_ge) begin
                        n_drem = VALUE_BITS'(w_shift - w_div);
                    end
                    n_prod = {r_prod[VALUE_BITS-2:0], w_ge};
                    n_dcnt = r_dcnt - DCNT_BITS'(1);
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register parts the sequencer from the response stall
    always_comb begin
        n_out_valid = r_out_valid;
        n_rsp       = r_rsp;
        if (w_load_out) begin
            n_out_valid  = 1'b1;
            n_rsp.value  = r_res_value;
            n_rsp.status = r_res_status;
        end else if (w_out_xfer) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_chosen     <= n_chosen;
        r_x          <= n_x;
        r_rem        <= n_rem;
        r_prod       <= n_prod;
        r_fac        <= n_fac;
        r_drem       <= n_drem;
        r_dcnt       <= n_dcnt;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        r_rsp        <= n_rsp;
    end

    // any error result carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (o_rsp.status != ST_OK)) |-> (o_rsp.value == '0))
        else $error("error result with nonzero value");

    // no status code beyond overflow ever leaves the block
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_rsp.status == ST_OK || o_rsp.status == ST_ORDER ||
                         o_rsp.status == ST_OVERFLOW))
        else $error("undefined status code");

    // partial remainder stays below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_drem < r_fac))
        else $error("divider remainder out of range");

    // an accepted request starts multiplying or finishes at once
    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_MUL || r_state == S_DONE))
        else $error("bad state after request transfer");

    // a loaded result shows on the output in the next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> o_valid)
        else $error("result load lost");

endmodule
